@@ design/tca_pkg.sv @@
`default_nettype none

package tca_pkg;

  localparam int unsigned SIDE_W      = 12;
  localparam int unsigned PERIM_W     = SIDE_W + 2;
  localparam int unsigned DIFF_W      = SIDE_W + 1;
  localparam int unsigned M1_W        = PERIM_W + DIFF_W;
  localparam int unsigned M2_W        = 2 * DIFF_W;
  localparam int unsigned FULL_W      = M1_W + M2_W;
  // 16 * area^2 <= P^4 / 27 keeps the radicand within this width
  localparam int unsigned RAD_W       = 4 * SIDE_W + 2;
  localparam int unsigned ROOT_W      = RAD_W / 2;
  localparam int unsigned REM_W       = ROOT_W + 2;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned IN_TDATA_W  = ((3 * SIDE_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAY_W   = PERIM_W + ROOT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 1 + KIND_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_EQUILATERAL = 2'd0,
    KIND_ISOSCELES   = 2'd1,
    KIND_SCALENE     = 2'd2
  } kind_e;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_step_t;

  // one restoring square root step: brings in two radicand bits, yields one root bit
  function automatic sq_step_t sqrt_step(input logic [REM_W-1:0]  rem,
                                         input logic [ROOT_W-1:0] root,
                                         input logic [1:0]        pair);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    sq_step_t         res;
    cur   = {rem[REM_W-3:0], pair};
    trial = {root, 2'b01};
    if (cur >= trial) begin
      res.rem  = cur - trial;
      res.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = cur;
      res.root = {root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/triangle_classify_area_core.sv @@
// triangle classifier and heron area unit
// input stream: one request per item carrying three unsigned side lengths;
//   accepted when s_axis_tvalid_i and s_axis_tready_o are both high
// output stream: exactly one result per request, in request order, with the
//   validity flag and triangle kind in tuser and perimeter and area_x4
//   (four times the heron area, truncated) in tdata; all zero when the sides
//   do not form a strict triangle
// pipeline: a stage of adds and compares, two multiply stages, then 25
//   square root stages of one root bit each
// throughput: one request per cycle while the output is not stalled, set by the fully pipelined datapath
// stall: every stage holds while the output register is full and
//   m_axis_tready_i is low; s_axis_tready_o drops for as long, so nothing is
//   lost or repeated
// reset: clears all stage valid bits; the pipeline comes up empty and ready
`default_nettype none

module triangle_classify_area_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  // side_a [11:0], side_b [23:12], side_c [35:24], zero fill above
  input  wire logic [tca_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // perimeter [13:0], area_x4 [38:14], zero fill above
  output      logic [tca_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // valid_res [0], kind [2:1]
  output      logic [tca_pkg::OUT_TUSER_W-1:0]   m_axis_tuser_o
);
  import tca_pkg::*;

  logic pipe_en;

  // stage 1: validity, kind, perimeter and the three differences
  logic [SIDE_W-1:0]  side_a, side_b, side_c;
  logic [DIFF_W-1:0]  sum_bc, sum_ac, sum_ab;
  logic               ok_a, ok_b, ok_c, tri_ok;
  logic [PERIM_W-1:0] perim;
  kind_e              kind;

  logic               s1_v_q;
  logic               s1_ok_q;
  kind_e              s1_kind_q;
  logic [PERIM_W-1:0] s1_perim_q;
  logic [DIFF_W-1:0]  s1_x_q, s1_y_q, s1_z_q;
  logic [DIFF_W-1:0]  s1_x_d, s1_y_d, s1_z_d;
  logic [PERIM_W-1:0] s1_perim_d;

  assign side_a = s_axis_tdata_i[SIDE_W-1:0];
  assign side_b = s_axis_tdata_i[2*SIDE_W-1:SIDE_W];
  assign side_c = s_axis_tdata_i[3*SIDE_W-1:2*SIDE_W];

  always_comb begin
    sum_bc = DIFF_W'(side_b) + DIFF_W'(side_c);
    sum_ac = DIFF_W'(side_a) + DIFF_W'(side_c);
    sum_ab = DIFF_W'(side_a) + DIFF_W'(side_b);
    ok_a   = sum_bc > DIFF_W'(side_a);
    ok_b   = sum_ac > DIFF_W'(side_b);
    ok_c   = sum_ab > DIFF_W'(side_c);
    tri_ok = ok_a && ok_b && ok_c;
    perim  = PERIM_W'(side_a) + PERIM_W'(side_b) + PERIM_W'(side_c);
    if (!tri_ok) begin
      kind = KIND_EQUILATERAL;
    end else if (side_a == side_b && side_b == side_c) begin
      kind = KIND_EQUILATERAL;
    end else if (side_a == side_b || side_a == side_c || side_b == side_c) begin
      kind = KIND_ISOSCELES;
    end else begin
      kind = KIND_SCALENE;
    end
    // zeroed terms force a zero product for a bad triangle
    s1_perim_d = tri_ok ? perim : '0;
    s1_x_d     = tri_ok ? sum_bc - DIFF_W'(side_a) : '0;
    s1_y_d     = tri_ok ? sum_ac - DIFF_W'(side_b) : '0;
    s1_z_d     = tri_ok ? sum_ab - DIFF_W'(side_c) : '0;
  end

  // stage 2: two partial products
  logic               s2_v_q;
  logic               s2_ok_q;
  kind_e              s2_kind_q;
  logic [PERIM_W-1:0] s2_perim_q;
  logic [M1_W-1:0]    s2_m1_q;
  logic [M2_W-1:0]    s2_m2_q;
  logic [M1_W-1:0]    s2_m1_d;
  logic [M2_W-1:0]    s2_m2_d;

  assign s2_m1_d = M1_W'(s1_perim_q) * M1_W'(s1_x_q);
  assign s2_m2_d = M2_W'(s1_y_q) * M2_W'(s1_z_q);

  // stage 3: radicand
  logic               s3_v_q;
  logic               s3_ok_q;
  kind_e              s3_kind_q;
  logic [PERIM_W-1:0] s3_perim_q;
  logic [RAD_W-1:0]   s3_rad_q;
  logic [FULL_W-1:0]  full_prod;

  assign full_prod = FULL_W'(s2_m1_q) * FULL_W'(s2_m2_q);

  // square root stages, one root bit each
  logic               sq_v_q     [ROOT_W];
  logic               sq_ok_q    [ROOT_W];
  kind_e              sq_kind_q  [ROOT_W];
  logic [PERIM_W-1:0] sq_perim_q [ROOT_W];
  logic [RAD_W-1:0]   sq_rad_q   [ROOT_W];
  logic [REM_W-1:0]   sq_rem_q   [ROOT_W];
  logic [ROOT_W-1:0]  sq_root_q  [ROOT_W];

  logic               sq_v_in     [ROOT_W];
  logic               sq_ok_in    [ROOT_W];
  kind_e              sq_kind_in  [ROOT_W];
  logic [PERIM_W-1:0] sq_perim_in [ROOT_W];
  logic [RAD_W-1:0]   sq_rad_in   [ROOT_W];
  logic [REM_W-1:0]   sq_rem_in   [ROOT_W];
  logic [ROOT_W-1:0]  sq_root_in  [ROOT_W];
  sq_step_t           sq_step_d   [ROOT_W];

  assign sq_v_in[0]     = s3_v_q;
  assign sq_ok_in[0]    = s3_ok_q;
  assign sq_kind_in[0]  = s3_kind_q;
  assign sq_perim_in[0] = s3_perim_q;
  assign sq_rad_in[0]   = s3_rad_q;
  assign sq_rem_in[0]   = '0;
  assign sq_root_in[0]  = '0;

  for (genvar k = 1; k < ROOT_W; k++) begin : g_sq_link
    assign sq_v_in[k]     = sq_v_q[k-1];
    assign sq_ok_in[k]    = sq_ok_q[k-1];
    assign sq_kind_in[k]  = sq_kind_q[k-1];
    assign sq_perim_in[k] = sq_perim_q[k-1];
    assign sq_rad_in[k]   = sq_rad_q[k-1];
    assign sq_rem_in[k]   = sq_rem_q[k-1];
    assign sq_root_in[k]  = sq_root_q[k-1];
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sq_step
    assign sq_step_d[k] = sqrt_step(sq_rem_in[k], sq_root_in[k],
                                    sq_rad_in[k][RAD_W-1:RAD_W-2]);
  end

  // global stall: everything moves when the output register can move
  assign pipe_en         = m_axis_tready_i || !sq_v_q[ROOT_W-1];
  assign s_axis_tready_o = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      for (int k = 0; k < ROOT_W; k++) begin
        sq_v_q[k] <= 1'b0;
      end
    end else if (pipe_en) begin
      s1_v_q <= s_axis_tvalid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      for (int k = 0; k < ROOT_W; k++) begin
        sq_v_q[k] <= sq_v_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_ok_q    <= tri_ok;
      s1_kind_q  <= kind;
      s1_perim_q <= s1_perim_d;
      s1_x_q     <= s1_x_d;
      s1_y_q     <= s1_y_d;
      s1_z_q     <= s1_z_d;

      s2_ok_q    <= s1_ok_q;
      s2_kind_q  <= s1_kind_q;
      s2_perim_q <= s1_perim_q;
      s2_m1_q    <= s2_m1_d;
      s2_m2_q    <= s2_m2_d;

      s3_ok_q    <= s2_ok_q;
      s3_kind_q  <= s2_kind_q;
      s3_perim_q <= s2_perim_q;
      s3_rad_q   <= full_prod[RAD_W-1:0];

      for (int k = 0; k < ROOT_W; k++) begin
        sq_ok_q[k]    <= sq_ok_in[k];
        sq_kind_q[k]  <= sq_kind_in[k];
        sq_perim_q[k] <= sq_perim_in[k];
        sq_rad_q[k]   <= {sq_rad_in[k][RAD_W-3:0], 2'b00};
        sq_rem_q[k]   <= sq_step_d[k].rem;
        sq_root_q[k]  <= sq_step_d[k].root;
      end
    end
  end

  assign m_axis_tvalid_o = sq_v_q[ROOT_W-1];
  assign m_axis_tdata_o  = OUT_TDATA_W'({sq_root_q[ROOT_W-1], sq_perim_q[ROOT_W-1]});
  assign m_axis_tuser_o  = {sq_kind_q[ROOT_W-1], sq_ok_q[ROOT_W-1]};

endmodule

`default_nettype wire
